// ===== src/lcs_pkg.sv =====
// Shared constants, action codes and cell control struct for the
// longest common substring block. No dependencies.
package lcs_pkg;

  localparam int unsigned MaxLen     = 64;
  localparam int unsigned LenWDef    = $clog2(MaxLen + 1);
  localparam int unsigned EndWDef    = $clog2(MaxLen);

  localparam int unsigned ActionW    = 2;
  localparam int unsigned CharW      = 8;
  localparam int unsigned StartW     = 6;
  localparam int unsigned LengthW    = 7;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 16;

  localparam logic [ActionW-1:0] ActStart  = 2'd0;
  localparam logic [ActionW-1:0] ActLoad   = 2'd1;
  localparam logic [ActionW-1:0] ActStream = 2'd2;
  localparam logic [ActionW-1:0] ActFinish = 2'd3;

  typedef struct packed {
    logic             clear;
    logic             stream;
    logic             rotate;
    logic [CharW-1:0] ch;
  } cell_ctl_t;

endpackage

// ===== src/lcs_cell.sv =====
// One cell of the match chain: stored second-string byte, run length and
// the best run seen by this cell. Depends on lcs_pkg.
module lcs_cell #(
  parameter int unsigned LEN_W = lcs_pkg::LenWDef,
  parameter int unsigned END_W = lcs_pkg::EndWDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lcs_pkg::cell_ctl_t            ctl_i,
  input  logic                          load_i,
  input  logic                          active_i,
  input  logic [END_W-1:0]              fcount_i,
  input  logic [LEN_W-1:0]              run_left_i,
  input  logic [LEN_W-1:0]              best_len_next_i,
  input  logic [END_W-1:0]              best_end_next_i,
  output logic [LEN_W-1:0]              run_o,
  output logic [LEN_W-1:0]              best_len_o,
  output logic [END_W-1:0]              best_end_o
);

  logic [lcs_pkg::CharW-1:0] byte_q;
  logic [LEN_W-1:0]          run_q;
  logic [LEN_W-1:0]          best_len_q;
  logic [END_W-1:0]          best_end_q;
  logic [LEN_W-1:0]          run_d;

  assign run_d = (active_i && (byte_q == ctl_i.ch)) ? run_left_i + LEN_W'(1) : '0;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      byte_q <= ctl_i.ch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= '0;
      best_len_q <= '0;
      best_end_q <= '0;
    end else if (ctl_i.clear) begin
      run_q      <= '0;
      best_len_q <= '0;
      best_end_q <= '0;
    end else if (load_i) begin
      run_q <= '0;
    end else if (ctl_i.stream) begin
      run_q <= run_d;
      if (run_d > best_len_q) begin
        best_len_q <= run_d;
        best_end_q <= fcount_i;
      end
    end else if (ctl_i.rotate) begin
      best_len_q <= best_len_next_i;
      best_end_q <= best_end_next_i;
    end
  end

  assign run_o      = run_q;
  assign best_len_o = best_len_q;
  assign best_end_o = best_end_q;

endmodule

// ===== src/lcs_best.sv =====
// Accumulator at the head of the chain: keeps the longest run and, on
// ties, the earliest end while the per-cell bests rotate past. Uses lcs_pkg.
module lcs_best #(
  parameter int unsigned LEN_W = lcs_pkg::LenWDef,
  parameter int unsigned END_W = lcs_pkg::EndWDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             en_i,
  input  logic [LEN_W-1:0] len_i,
  input  logic [END_W-1:0] end_i,
  output logic [LEN_W-1:0] len_o,
  output logic [END_W-1:0] end_o
);

  logic [LEN_W-1:0] len_q;
  logic [END_W-1:0] end_q;
  logic             take;

  assign take = (len_i > len_q) ||
                ((len_i == len_q) && (len_i != '0) && (end_i < end_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      end_q <= '0;
    end else if (clear_i) begin
      len_q <= '0;
      end_q <= '0;
    end else if (en_i && take) begin
      len_q <= len_i;
      end_q <= end_i;
    end
  end

  assign len_o = len_q;
  assign end_o = end_q;

endmodule

// ===== src/longest_common_substring.sv =====
// Top level of the longest common substring block: control, chain of
// match cells and best-run accumulator. Depends on lcs_pkg, lcs_cell, lcs_best.
//
// Input channel s_axis carries one command per transfer: start (clear all
// state), load (append a second-string byte), stream (present the next
// first-string byte) or finish. Start, load and stream produce nothing;
// a stream updates the whole row of cells at once. Bytes past MAX_LEN on
// either string are dropped and set the overflow bit. Finish rotates the
// per-cell best runs once around the chain into the accumulator in the
// sweep state, then the result is registered onto m_axis in the done
// state. s_axis_tready stays low during that sweep; commands are taken
// again while a result waits on m_axis. A second finish whose result is
// ready while m_axis is still stalled holds until the first result is
// taken. Reset clears all run, best and count state and empties m_axis.
module longest_common_substring #(
  parameter int unsigned MAX_LEN = lcs_pkg::MaxLen
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [1:0] action, [9:2] char_in, [15:10] zero
  input  logic [lcs_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] found, [6:1] match_start, [13:7] match_length, [14] overflow, [15] zero
  output logic [lcs_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned EW = $clog2(MAX_LEN);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSweep = 2'd1;
  localparam logic [1:0] StDone  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [LW-1:0] second_count_q, second_count_d;
  logic [LW-1:0] first_count_q, first_count_d;
  logic          dropped_q, dropped_d;
  logic [EW-1:0] sweep_cnt_q, sweep_cnt_d;
  logic          m_valid_q, m_valid_d;
  logic [lcs_pkg::OutDataW-1:0] m_data_q, m_data_d;

  logic                          in_xfer;
  logic [lcs_pkg::ActionW-1:0]   action;
  logic [lcs_pkg::CharW-1:0]     char_in;
  logic                          load_go;
  logic                          acc_clear;
  lcs_pkg::cell_ctl_t            ctl;

  logic [MAX_LEN-1:0] load_en;
  logic [MAX_LEN-1:0] active;
  logic [LW-1:0]      run_w      [MAX_LEN];
  logic [LW-1:0]      best_len_w [MAX_LEN];
  logic [EW-1:0]      best_end_w [MAX_LEN];

  logic [LW-1:0] acc_len;
  logic [EW-1:0] acc_end;
  logic          found;
  logic [LW-1:0] start_full;
  logic [lcs_pkg::StartW-1:0]  match_start;
  logic [lcs_pkg::LengthW-1:0] match_length;

  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign action        = s_axis_tdata[lcs_pkg::ActionW-1:0];
  assign char_in       = s_axis_tdata[lcs_pkg::ActionW +: lcs_pkg::CharW];

  always_comb begin
    state_d        = state_q;
    second_count_d = second_count_q;
    first_count_d  = first_count_q;
    dropped_d      = dropped_q;
    sweep_cnt_d    = sweep_cnt_q;
    m_valid_d      = m_valid_q && !m_axis_tready;
    m_data_d       = m_data_q;
    load_go        = 1'b0;
    acc_clear      = 1'b0;
    ctl            = '0;
    ctl.ch         = char_in;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          case (action)
            lcs_pkg::ActStart: begin
              ctl.clear      = 1'b1;
              second_count_d = '0;
              first_count_d  = '0;
              dropped_d      = 1'b0;
            end
            lcs_pkg::ActLoad: begin
              if (second_count_q < LW'(MAX_LEN)) begin
                load_go        = 1'b1;
                second_count_d = second_count_q + LW'(1);
              end else begin
                dropped_d = 1'b1;
              end
            end
            lcs_pkg::ActStream: begin
              if (first_count_q < LW'(MAX_LEN)) begin
                ctl.stream    = 1'b1;
                first_count_d = first_count_q + LW'(1);
              end else begin
                dropped_d = 1'b1;
              end
            end
            lcs_pkg::ActFinish: begin
              acc_clear   = 1'b1;
              sweep_cnt_d = '0;
              state_d     = StSweep;
            end
            default: begin
            end
          endcase
        end
      end
      StSweep: begin
        ctl.rotate  = 1'b1;
        sweep_cnt_d = sweep_cnt_q + EW'(1);
        if (sweep_cnt_q == EW'(MAX_LEN - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {1'b0, dropped_q, match_length, match_start, found};
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      second_count_q <= '0;
      first_count_q  <= '0;
      dropped_q      <= 1'b0;
      sweep_cnt_q    <= '0;
      m_valid_q      <= 1'b0;
    end else begin
      state_q        <= state_d;
      second_count_q <= second_count_d;
      first_count_q  <= first_count_d;
      dropped_q      <= dropped_d;
      sweep_cnt_q    <= sweep_cnt_d;
      m_valid_q      <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    assign load_en[j] = load_go && (second_count_q == LW'(j));
    assign active[j]  = (LW'(j) < second_count_q);

    lcs_cell #(
      .LEN_W (LW),
      .END_W (EW)
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .ctl_i           (ctl),
      .load_i          (load_en[j]),
      .active_i        (active[j]),
      .fcount_i        (first_count_q[EW-1:0]),
      .run_left_i      ((j == 0) ? LW'(0) : run_w[(j == 0) ? 0 : j - 1]),
      .best_len_next_i (best_len_w[(j + 1) % MAX_LEN]),
      .best_end_next_i (best_end_w[(j + 1) % MAX_LEN]),
      .run_o           (run_w[j]),
      .best_len_o      (best_len_w[j]),
      .best_end_o      (best_end_w[j])
    );
  end

  lcs_best #(
    .LEN_W (LW),
    .END_W (EW)
  ) u_best (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (acc_clear),
    .en_i    (ctl.rotate),
    .len_i   (best_len_w[0]),
    .end_i   (best_end_w[0]),
    .len_o   (acc_len),
    .end_o   (acc_end)
  );

  assign found        = (acc_len != '0);
  assign start_full   = LW'(acc_end) + LW'(1) - acc_len;
  assign match_start  = found ? lcs_pkg::StartW'(start_full) : '0;
  assign match_length = lcs_pkg::LengthW'(acc_len);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== src/lcs_chk.sv =====
// Port-level checker for the longest common substring block and its bind
// to the top level. Depends on lcs_pkg.
module lcs_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [lcs_pkg::InDataW-1:0]  s_axis_tdata,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [lcs_pkg::OutDataW-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_found_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[13:7] != 7'd0)))
    else $error("found flag disagrees with length");

  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[6:1] == 6'd0))
    else $error("start nonzero without a match");

  a_finish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready &&
    (s_axis_tdata[1:0] == lcs_pkg::ActFinish) |=> !s_axis_tready)
    else $error("command taken during result sweep");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a finish");

endmodule

bind longest_common_substring lcs_chk u_lcs_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
